// File: rtl/lsi_pkg.sv
// Package: shared types and constants of the two-axis linear step interpolator.
`timescale 1ns / 1ps

package lsi_pkg;

   // Position and arithmetic widths
   localparam int POS_W        = 16;
   localparam int SETTLE_TICKS = 10;
   localparam int COORD_W      = 16;
   localparam int LIMIT_W      = 16;
   localparam int GAP_W        = 16;
   localparam int PULSE_W      = 8;
   localparam int TIMER_W      = 16;
   localparam int POS_OUT_W    = 16;
   localparam int CSR_W        = 16;
   localparam int CSR_IDX_W    = 3;
   localparam int WIDE_W       = (POS_W > COORD_W) ? POS_W : COORD_W;
   // quarter-step targets: 4*position + 5*coordinate, signed
   localparam int Q_W          = WIDE_W + 4;
   localparam int ACC_W        = POS_W + 1;

   typedef enum logic [1:0] {
      OP_ABS  = 2'd0,
      OP_REL  = 2'd1,
      OP_HOME = 2'd2,
      OP_TICK = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_NONE     = 2'd0,
      STATUS_ACCEPTED = 2'd1,
      STATUS_RANGE    = 2'd2,
      STATUS_BUSY     = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAP     = 3'd0,
      CSR_PULSE   = 3'd1,
      CSR_X_LIMIT = 3'd2,
      CSR_Y_LIMIT = 3'd3,
      CSR_MOTORS  = 3'd4
   } csr_index_type;

   typedef struct packed {
      op_type                     op;
      logic signed [COORD_W-1:0]  coord_x;
      logic signed [COORD_W-1:0]  coord_y;
   } req_type;

   typedef struct packed {
      logic                  step_x;
      logic                  step_y;
      logic                  dir_x;
      logic                  dir_y;
      logic                  enable_n;
      logic                  busy_res;
      status_type            status;
      logic [POS_OUT_W-1:0]  pos_x;
      logic [POS_OUT_W-1:0]  pos_y;
   } rsp_type;

   // Classified command: coordinates already scaled to quarter steps
   typedef struct packed {
      op_type                 op;
      logic signed [Q_W-1:0]  qx;
      logic signed [Q_W-1:0]  qy;
   } cmd_type;

   typedef struct packed {
      logic [GAP_W-1:0]    gap_ticks;
      logic [PULSE_W-1:0]  pulse_ticks;
      logic [LIMIT_W-1:0]  x_limit_steps;
      logic [LIMIT_W-1:0]  y_limit_steps;
      logic                motors_on;
   } cfg_type;

endpackage

// File: rtl/lsi_front.sv
// Front end: accepts request transactions, scales coordinates, queues commands.
`timescale 1ns / 1ps

module lsi_front import lsi_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   output logic     full,
   input  req_type  req_data,
   output logic     cmd_valid,
   output cmd_type  cmd,
   input  logic     cmd_pop
);

   cmd_type     entry_ff [2];
   cmd_type     cmd_in;
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;

   // Scale to quarter steps: 5*c, home targets the origin
   always_comb begin
      cmd_in.op = req_data.op;
      if (req_data.op == OP_HOME) begin
         cmd_in.qx = '0;
         cmd_in.qy = '0;
      end else begin
         cmd_in.qx = (Q_W'(req_data.coord_x) <<< 2) + Q_W'(req_data.coord_x);
         cmd_in.qy = (Q_W'(req_data.coord_y) <<< 2) + Q_W'(req_data.coord_y);
      end
   end

   assign full      = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   // Advance pointers and store the command
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

// File: rtl/lsi_exec.sv
// Back end: move acceptance, settle and step pulse timing, Bresenham pacing.
`timescale 1ns / 1ps

module lsi_exec import lsi_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     cmd_valid,
   input  cmd_type  cmd,
   output logic     cmd_pop,
   input  logic     rsp_full,
   output logic     rsp_push,
   output rsp_type  rsp
);

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_SETTLE = 2'd1,
      PH_HIGH   = 2'd2,
      PH_GAP    = 2'd3
   } phase_type;

   typedef struct packed {
      logic [ACC_W-1:0]  accum_x;
      logic [ACC_W-1:0]  accum_y;
      logic [1:0]        flags;
   } iter_type;

   phase_type           phase_ff, phase_in;
   logic [TIMER_W-1:0]  timer_ff, timer_in;
   logic [1:0]          flags_ff, flags_in;
   logic [POS_W-1:0]    position_x_ff, position_x_in, position_y_ff, position_y_in;
   logic [POS_W-1:0]    target_x_ff, target_x_in, target_y_ff, target_y_in;
   logic [POS_W-1:0]    span_x_ff, span_x_in, span_y_ff, span_y_in;
   logic [POS_W-1:0]    major_ff, major_in;
   logic [POS_W-1:0]    iteration_ff, iteration_in;
   logic [ACC_W-1:0]    accum_x_ff, accum_x_in, accum_y_ff, accum_y_in;
   logic                dir_x_ff, dir_x_in, dir_y_ff, dir_y_in;
   status_type          status;
   logic [1:0]          levels;
   logic                fire;
   logic [TIMER_W-1:0]  pulse_eff, gap_eff;

   // One Bresenham iteration: add the spans, wrap and flag on overflow
   function automatic iter_type start_iter(input logic [ACC_W-1:0] ax,
                                           input logic [ACC_W-1:0] ay,
                                           input logic [POS_W-1:0] sx,
                                           input logic [POS_W-1:0] sy,
                                           input logic [POS_W-1:0] mj);
      iter_type          r;
      logic [ACC_W-1:0]  nx, ny, mjw;
      mjw     = {1'b0, mj};
      nx      = ax + {1'b0, sx};
      ny      = ay + {1'b0, sy};
      r.flags = 2'b00;
      if (nx >= mjw) begin
         nx         = nx - mjw;
         r.flags[0] = 1'b1;
      end
      if (ny >= mjw) begin
         ny         = ny - mjw;
         r.flags[1] = 1'b1;
      end
      r.accum_x = nx;
      r.accum_y = ny;
      return r;
   endfunction

   assign fire      = cmd_valid && !rsp_full;
   assign cmd_pop   = fire;
   assign rsp_push  = fire;
   assign pulse_eff = (cfg.pulse_ticks == '0) ? TIMER_W'(1) : TIMER_W'(cfg.pulse_ticks);
   assign gap_eff   = (cfg.gap_ticks == '0) ? TIMER_W'(1) : TIMER_W'(cfg.gap_ticks);
   assign levels    = (phase_ff == PH_HIGH) ? flags_ff : 2'b00;

   // Execute one command or tick
   always_comb begin
      logic signed [Q_W-1:0]  qx, qy, lim_x, lim_y;
      logic [Q_W-1:0]         rx, ry;
      logic [POS_W-1:0]       tx, ty, sx, sy, mj;
      logic signed [POS_W:0]  dx, dy;
      logic [POS_W:0]         ndx, ndy;
      logic [TIMER_W-1:0]     tnext;
      logic [POS_W:0]         iter_next;
      logic                   ok;
      iter_type               it;

      qx        = '0;
      qy        = '0;
      lim_x     = signed'({{(Q_W-LIMIT_W-2){1'b0}}, cfg.x_limit_steps, 2'b00});
      lim_y     = signed'({{(Q_W-LIMIT_W-2){1'b0}}, cfg.y_limit_steps, 2'b00});
      rx        = '0;
      ry        = '0;
      tx        = '0;
      ty        = '0;
      sx        = '0;
      sy        = '0;
      mj        = '0;
      dx        = '0;
      dy        = '0;
      ndx       = '0;
      ndy       = '0;
      tnext     = '0;
      iter_next = '0;
      ok        = 1'b0;
      it        = '0;

      phase_in      = phase_ff;
      timer_in      = timer_ff;
      flags_in      = flags_ff;
      position_x_in = position_x_ff;
      position_y_in = position_y_ff;
      target_x_in   = target_x_ff;
      target_y_in   = target_y_ff;
      span_x_in     = span_x_ff;
      span_y_in     = span_y_ff;
      major_in      = major_ff;
      iteration_in  = iteration_ff;
      accum_x_in    = accum_x_ff;
      accum_y_in    = accum_y_ff;
      dir_x_in      = dir_x_ff;
      dir_y_in      = dir_y_ff;
      status        = STATUS_NONE;

      if (fire) begin
         if (cmd.op == OP_TICK) begin
            // Advance pulse timing by one tick
            if (phase_ff != PH_IDLE) begin
               tnext    = (timer_ff != '0) ? timer_ff - TIMER_W'(1) : '0;
               timer_in = tnext;
               if (tnext == '0) begin
                  unique case (phase_ff)
                     PH_SETTLE: begin
                        it         = start_iter(accum_x_ff, accum_y_ff, span_x_ff,
                                                span_y_ff, major_ff);
                        accum_x_in = it.accum_x;
                        accum_y_in = it.accum_y;
                        flags_in   = it.flags;
                        phase_in   = PH_HIGH;
                        timer_in   = pulse_eff;
                     end
                     PH_HIGH: begin
                        flags_in = 2'b00;
                        phase_in = PH_GAP;
                        timer_in = gap_eff;
                     end
                     PH_GAP: begin
                        iter_next    = {1'b0, iteration_ff} + (POS_W+1)'(1);
                        iteration_in = iter_next[POS_W-1:0];
                        if (iter_next >= {1'b0, major_ff}) begin
                           position_x_in = target_x_ff;
                           position_y_in = target_y_ff;
                           phase_in      = PH_IDLE;
                        end else begin
                           it         = start_iter(accum_x_ff, accum_y_ff, span_x_ff,
                                                   span_y_ff, major_ff);
                           accum_x_in = it.accum_x;
                           accum_y_in = it.accum_y;
                           flags_in   = it.flags;
                           phase_in   = PH_HIGH;
                           timer_in   = pulse_eff;
                        end
                     end
                     default: begin
                        phase_in = PH_IDLE;
                     end
                  endcase
               end
            end
         end else if (phase_ff != PH_IDLE) begin
            // Reject a move while one runs
            status = STATUS_BUSY;
         end else begin
            // Range test in quarter steps, then round to steps
            if (cmd.op == OP_REL) begin
               qx = cmd.qx + signed'({{(Q_W-POS_W-2){1'b0}}, position_x_ff, 2'b00});
               qy = cmd.qy + signed'({{(Q_W-POS_W-2){1'b0}}, position_y_ff, 2'b00});
            end else begin
               qx = cmd.qx;
               qy = cmd.qy;
            end
            ok = !qx[Q_W-1] && (qx <= lim_x) && !qy[Q_W-1] && (qy <= lim_y);
            rx = qx + Q_W'(2);
            ry = qy + Q_W'(2);
            tx = rx[POS_W+1:2];
            ty = ry[POS_W+1:2];
            if (!ok) begin
               status = STATUS_RANGE;
            end else begin
               status      = STATUS_ACCEPTED;
               dx          = signed'({1'b0, tx}) - signed'({1'b0, position_x_ff});
               dy          = signed'({1'b0, ty}) - signed'({1'b0, position_y_ff});
               ndx         = -dx;
               ndy         = -dy;
               sx          = dx[POS_W] ? ndx[POS_W-1:0] : dx[POS_W-1:0];
               sy          = dy[POS_W] ? ndy[POS_W-1:0] : dy[POS_W-1:0];
               mj          = (sx > sy) ? sx : sy;
               target_x_in = tx;
               target_y_in = ty;
               span_x_in   = sx;
               span_y_in   = sy;
               major_in    = mj;
               if (mj == '0) begin
                  // Zero-length move commits at once
                  position_x_in = tx;
                  position_y_in = ty;
               end else begin
                  if (dx != '0) begin
                     dir_x_in = !dx[POS_W];
                  end
                  if (dy != '0) begin
                     dir_y_in = !dy[POS_W];
                  end
                  iteration_in = '0;
                  accum_x_in   = {2'b00, mj[POS_W-1:1]};
                  accum_y_in   = {2'b00, mj[POS_W-1:1]};
                  flags_in     = 2'b00;
                  phase_in     = PH_SETTLE;
                  timer_in     = TIMER_W'(SETTLE_TICKS);
                  if (SETTLE_TICKS == 0) begin
                     it         = start_iter({2'b00, mj[POS_W-1:1]},
                                             {2'b00, mj[POS_W-1:1]}, sx, sy, mj);
                     accum_x_in = it.accum_x;
                     accum_y_in = it.accum_y;
                     flags_in   = it.flags;
                     phase_in   = PH_HIGH;
                     timer_in   = pulse_eff;
                  end
               end
            end
         end
      end
   end

   // Result transaction
   always_comb begin
      rsp.step_x   = levels[0];
      rsp.step_y   = levels[1];
      rsp.dir_x    = dir_x_in;
      rsp.dir_y    = dir_y_in;
      rsp.enable_n = !cfg.motors_on;
      rsp.busy_res = (phase_in != PH_IDLE);
      rsp.status   = status;
      rsp.pos_x    = POS_OUT_W'(position_x_in);
      rsp.pos_y    = POS_OUT_W'(position_y_in);
   end

   // Hold motion state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         timer_ff      <= '0;
         flags_ff      <= 2'b00;
         position_x_ff <= '0;
         position_y_ff <= '0;
         target_x_ff   <= '0;
         target_y_ff   <= '0;
         span_x_ff     <= '0;
         span_y_ff     <= '0;
         major_ff      <= '0;
         iteration_ff  <= '0;
         accum_x_ff    <= '0;
         accum_y_ff    <= '0;
         dir_x_ff      <= 1'b0;
         dir_y_ff      <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         timer_ff      <= timer_in;
         flags_ff      <= flags_in;
         position_x_ff <= position_x_in;
         position_y_ff <= position_y_in;
         target_x_ff   <= target_x_in;
         target_y_ff   <= target_y_in;
         span_x_ff     <= span_x_in;
         span_y_ff     <= span_y_in;
         major_ff      <= major_in;
         iteration_ff  <= iteration_in;
         accum_x_ff    <= accum_x_in;
         accum_y_ff    <= accum_y_in;
         dir_x_ff      <= dir_x_in;
         dir_y_ff      <= dir_y_in;
      end
   end

endmodule

// File: rtl/lsi_rsp_queue.sv
// Two-entry result queue between the execution stage and the result port.
`timescale 1ns / 1ps

module lsi_rsp_queue import lsi_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     rsp_push,
   input  rsp_type  rsp_in_data,
   output logic     rsp_full,
   input  logic     pop,
   output logic     empty,
   output rsp_type  rsp_data
);

   rsp_type     entry_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;

   assign rsp_full = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign rsp_data = entry_ff[rd_ptr_ff];
   assign do_push  = rsp_push && !rsp_full;
   assign do_pop   = pop && !empty;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   // Advance pointers and store the result
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= rsp_in_data;
      end
   end

endmodule

// File: rtl/two_axis_linear_step_interpolator_top.sv
// Top level: configuration registers and the front, execution and result stages.
`timescale 1ns / 1ps

// Two-axis linear step interpolator. Every request transaction (move or tick) yields
// exactly one result transaction, in order. The block takes one transaction per clock
// cycle while neither queue is full; the command queue registers the request, and the
// execution stage handles one command per cycle unless the result queue is full and
// writes its result into the result queue at the next edge, from which it is read at the
// result ports. Both queues hold two entries, so either side may stall without stopping
// the other until its queue fills. Registers are written through the csr port and should
// change only while no transaction is in flight.

module two_axis_linear_step_interpolator_top import lsi_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  req_type               req_data,
   output logic                  empty,
   input  logic                  pop,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_wdata
);

   cfg_type  cfg_ff;
   logic     cmd_valid, cmd_pop;
   cmd_type  cmd;
   logic     rsp_full, rsp_push;
   rsp_type  rsp_next;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gap_ticks     <= GAP_W'(500);
         cfg_ff.pulse_ticks   <= PULSE_W'(5);
         cfg_ff.x_limit_steps <= LIMIT_W'(32000);
         cfg_ff.y_limit_steps <= LIMIT_W'(32000);
         cfg_ff.motors_on     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GAP:     cfg_ff.gap_ticks     <= csr_wdata[GAP_W-1:0];
            CSR_PULSE:   cfg_ff.pulse_ticks   <= csr_wdata[PULSE_W-1:0];
            CSR_X_LIMIT: cfg_ff.x_limit_steps <= csr_wdata[LIMIT_W-1:0];
            CSR_Y_LIMIT: cfg_ff.y_limit_steps <= csr_wdata[LIMIT_W-1:0];
            CSR_MOTORS:  cfg_ff.motors_on     <= csr_wdata[0];
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   lsi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   lsi_exec u_exec (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_next)
   );

   lsi_rsp_queue u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .rsp_push    (rsp_push),
      .rsp_in_data (rsp_next),
      .rsp_full    (rsp_full),
      .pop         (pop),
      .empty       (empty),
      .rsp_data    (rsp_data)
   );

endmodule
